// ===== design/hashed_trie_symbol_interner_defines.svh =====
// Assertion macros shared by the hashed trie symbol interner RTL.
// Depends on nothing; asserting modules must have clk and rst_n in scope.
`ifndef HASHED_TRIE_SYMBOL_INTERNER_DEFINES_SVH
`define HASHED_TRIE_SYMBOL_INTERNER_DEFINES_SVH
`ifndef ASSERT_OFF
`define HTSI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HTSI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HTSI_ASSERT(lbl, prop, msg)
`define HTSI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/htsi_pkg.sv =====
// Types, constants and the microcode program of the hashed trie symbol interner.
// Depends on nothing.
package htsi_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int CHAR_W          = 8;
    localparam int NODE_W          = 12;
    localparam int LEN_W           = 9;
    localparam int SIZE_W          = 13;
    localparam int PROD_W          = 2 * CHAR_W;
    localparam int DIV_W           = PROD_W + 1;
    localparam int PC_W            = 5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'h821;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 13'd3;
    localparam logic [CHAR_W-1:0] ROOT_CHAR  = 8'h3F;
    localparam logic [LEN_W-1:0]  LEN_MAX    = 9'd511;

    localparam logic CMD_INTERN = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [CHAR_W-1:0] ch;
        logic              first;
    } item_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [LEN_W-1:0]  prefix_length;
        logic              inserted;
        logic              overflow;
    } result_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LATCH,
        ACT_BEGIN,
        ACT_MUL,
        ACT_SAVE_STEP,
        ACT_SAVE_HOME,
        ACT_READ,
        ACT_ADVANCE,
        ACT_INSERT,
        ACT_ACCEPT_NODE,
        ACT_SET_OVF,
        ACT_EMIT,
        ACT_CLR_INIT,
        ACT_CLR_WRITE
    } act_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_IS_CLEAR,
        C_SKIP,
        C_MOD_BUSY,
        C_HIT,
        C_EMPTY,
        C_NEXT_HOME,
        C_CLR_MORE
    } cond_t;

    typedef struct packed {
        act_t            act;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic start;
        logic is_clear;
        logic skip;
        logic mod_busy;
        logic hit;
        logic empty;
        logic next_home;
        logic clr_more;
    } flags_t;

    localparam logic [PC_W-1:0] S_IDLE        = 5'd0;
    localparam logic [PC_W-1:0] S_DISPATCH    = 5'd1;
    localparam logic [PC_W-1:0] S_MUL         = 5'd2;
    localparam logic [PC_W-1:0] S_WAIT_STEP   = 5'd3;
    localparam logic [PC_W-1:0] S_STEP        = 5'd4;
    localparam logic [PC_W-1:0] S_WAIT_HOME   = 5'd5;
    localparam logic [PC_W-1:0] S_HOME        = 5'd6;
    localparam logic [PC_W-1:0] S_READ        = 5'd7;
    localparam logic [PC_W-1:0] S_CHECK       = 5'd8;
    localparam logic [PC_W-1:0] S_CHECK_EMPTY = 5'd9;
    localparam logic [PC_W-1:0] S_ADVANCE     = 5'd10;
    localparam logic [PC_W-1:0] S_REREAD      = 5'd11;
    localparam logic [PC_W-1:0] S_INSERT      = 5'd12;
    localparam logic [PC_W-1:0] S_FOUND       = 5'd13;
    localparam logic [PC_W-1:0] S_OVF         = 5'd14;
    localparam logic [PC_W-1:0] S_EMIT        = 5'd15;
    localparam logic [PC_W-1:0] S_CLR_INIT    = 5'd16;
    localparam logic [PC_W-1:0] S_CLR_LOOP    = 5'd17;
    localparam logic [PC_W-1:0] S_CLR_DONE    = 5'd18;
    localparam logic [PC_W-1:0] S_RST_INIT    = 5'd19;
    localparam logic [PC_W-1:0] S_RST_LOOP    = 5'd20;
    localparam logic [PC_W-1:0] S_RST_DONE    = 5'd21;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{act: ACT_NONE, cond: C_ALWAYS, target: S_IDLE};
        unique case (pc)
            S_IDLE:        w = '{act: ACT_LATCH,       cond: C_NO_START,  target: S_IDLE};
            S_DISPATCH:    w = '{act: ACT_BEGIN,       cond: C_IS_CLEAR,  target: S_CLR_INIT};
            S_MUL:         w = '{act: ACT_MUL,         cond: C_SKIP,      target: S_EMIT};
            S_WAIT_STEP:   w = '{act: ACT_NONE,        cond: C_MOD_BUSY,  target: S_WAIT_STEP};
            S_STEP:        w = '{act: ACT_SAVE_STEP,   cond: C_NEVER,     target: S_IDLE};
            S_WAIT_HOME:   w = '{act: ACT_NONE,        cond: C_MOD_BUSY,  target: S_WAIT_HOME};
            S_HOME:        w = '{act: ACT_SAVE_HOME,   cond: C_NEVER,     target: S_IDLE};
            S_READ:        w = '{act: ACT_READ,        cond: C_NEVER,     target: S_IDLE};
            S_CHECK:       w = '{act: ACT_NONE,        cond: C_HIT,       target: S_FOUND};
            S_CHECK_EMPTY: w = '{act: ACT_NONE,        cond: C_EMPTY,     target: S_INSERT};
            S_ADVANCE:     w = '{act: ACT_ADVANCE,     cond: C_NEXT_HOME, target: S_OVF};
            S_REREAD:      w = '{act: ACT_READ,        cond: C_ALWAYS,    target: S_CHECK};
            S_INSERT:      w = '{act: ACT_INSERT,      cond: C_NEVER,     target: S_IDLE};
            S_FOUND:       w = '{act: ACT_ACCEPT_NODE, cond: C_ALWAYS,    target: S_EMIT};
            S_OVF:         w = '{act: ACT_SET_OVF,     cond: C_NEVER,     target: S_IDLE};
            S_EMIT:        w = '{act: ACT_EMIT,        cond: C_ALWAYS,    target: S_IDLE};
            S_CLR_INIT:    w = '{act: ACT_CLR_INIT,    cond: C_NEVER,     target: S_IDLE};
            S_CLR_LOOP:    w = '{act: ACT_CLR_WRITE,   cond: C_CLR_MORE,  target: S_CLR_LOOP};
            S_CLR_DONE:    w = '{act: ACT_NONE,        cond: C_ALWAYS,    target: S_EMIT};
            S_RST_INIT:    w = '{act: ACT_CLR_INIT,    cond: C_NEVER,     target: S_IDLE};
            S_RST_LOOP:    w = '{act: ACT_CLR_WRITE,   cond: C_CLR_MORE,  target: S_RST_LOOP};
            S_RST_DONE:    w = '{act: ACT_NONE,        cond: C_ALWAYS,    target: S_IDLE};
            default:       w = '{act: ACT_NONE,        cond: C_ALWAYS,    target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== design/htsi_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module htsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/htsi_mod.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on htsi_pkg.
module htsi_mod
    import htsi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              busy,
    output logic [SIZE_W-1:0] rem
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [DIV_W-1:0]  dvd_reg,  dvd_next;
    logic [SIZE_W-1:0] rem_reg,  rem_next;
    logic [SIZE_W:0]   shifted;
    logic [SIZE_W:0]   diff;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[DIV_W-1]};
        diff     = shifted - {1'b0, divisor};
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIV_W);
            dvd_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            rem_next = (shifted >= {1'b0, divisor}) ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign busy = (cnt_reg != '0);
    assign rem  = rem_reg;

endmodule

// ===== design/htsi_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on htsi_pkg and hashed_trie_symbol_interner_defines.svh.
`include "hashed_trie_symbol_interner_defines.svh"
module htsi_seq
    import htsi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output ucode_t ctrl,
    output logic   busy
);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            take;

    assign ctrl = ucode_rom(pc_reg);
    assign busy = (pc_reg != S_IDLE);

    always_comb
    begin
        unique case (ctrl.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_START:  take = !flags.start;
            C_IS_CLEAR:  take = flags.is_clear;
            C_SKIP:      take = flags.skip;
            C_MOD_BUSY:  take = flags.mod_busy;
            C_HIT:       take = flags.hit;
            C_EMPTY:     take = flags.empty;
            C_NEXT_HOME: take = flags.next_home;
            C_CLR_MORE:  take = flags.clr_more;
            default:     take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_RST_INIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    `HTSI_ASSERT(a_accept_goes_busy, flags.start && !busy |=> busy, "accepted transaction did not start")
    `HTSI_ASSERT(a_emit_returns_idle, ctrl.act == ACT_EMIT |=> !busy, "no return to idle after result")
    `HTSI_ASSERT(a_clr_ends_in_emit, pc_reg == S_CLR_LOOP && !flags.clr_more |=> ctrl.act == ACT_EMIT || pc_reg == S_CLR_DONE, "clear pass did not finish")
    `HTSI_ASSERT_ALWAYS(a_idle_latches, !busy |-> ctrl.act == ACT_LATCH, "idle step does not latch input")

endmodule

// ===== design/hashed_trie_symbol_interner.sv =====
// Top level of the hashed trie symbol interner: datapath around the sequencer.
// Depends on htsi_pkg, htsi_seq, htsi_mod, htsi_ram and the defines header.
//
// Interns names one character per transaction. After reset, and for every clear
// command, a clearing pass writes every one of the TABLE_DEPTH entries, one per
// cycle. Busy stays high after reset until that pass is done, and a clear transaction
// gives its result after its pass is done. An intern transaction first runs the
// bit-serial remainder unit for the probe step and then for the home slot, and then
// reads the home slot through the single read port of the table. A hit takes the
// entry and an empty slot is claimed; otherwise the probe advances by the step and the
// slot is read again, and a probe that comes back to the home slot sets overflow.
// A zero character, or a name already in overflow, skips the search and goes
// straight to the result. Busy drops in the cycle after each result. Each result is
// shown for one cycle with result_valid and cannot be held off by the receiver. The
// size register is written only while the block is idle: cfg_ready follows !busy.
`include "hashed_trie_symbol_interner_defines.svh"
module hashed_trie_symbol_interner
    import htsi_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              result_valid,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int ENT_W = CHAR_W + IDX_W;

    ucode_t ctrl;
    flags_t flags;

    item_t             item_reg,  item_next;
    logic [IDX_W-1:0]  cur_reg,   cur_next;
    logic [LEN_W-1:0]  len_reg,   len_next;
    logic              ovf_reg,   ovf_next;
    logic              ins_reg,   ins_next;
    logic [PROD_W-1:0] prod_reg,  prod_next;
    logic [SIZE_W-1:0] step_reg,  step_next;
    logic [SIZE_W-1:0] home_reg,  home_next;
    logic [SIZE_W-1:0] probe_reg, probe_next;
    logic [IDX_W-1:0]  clr_reg,   clr_next;
    logic [SIZE_W-1:0] size_reg;

    logic [SIZE_W-1:0] eff_size;
    logic [SIZE_W:0]   probe_sum;
    logic [SIZE_W-1:0] probe_wrap;
    logic              mod_start;
    logic [DIV_W-1:0]  mod_dividend;
    logic              mod_busy;
    logic [SIZE_W-1:0] mod_rem;

    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [ENT_W-1:0]  ram_wr_data;
    logic              ram_rd_en;
    logic [ENT_W-1:0]  ram_rd_data;
    logic [CHAR_W-1:0] rd_char;
    logic [IDX_W-1:0]  rd_parent;

    htsi_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    htsi_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (eff_size),
        .busy     (mod_busy),
        .rem      (mod_rem)
    );

    htsi_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (IDX_W'(probe_reg)),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        if (size_reg < SIZE_MIN)
        begin
            eff_size = SIZE_MIN;
        end
        else if (32'(size_reg) > TABLE_DEPTH)
        begin
            eff_size = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            eff_size = size_reg;
        end
    end

    assign rd_char    = ram_rd_data[ENT_W-1 -: CHAR_W];
    assign rd_parent  = ram_rd_data[IDX_W-1:0];
    assign probe_sum  = {1'b0, probe_reg} + {1'b0, step_reg};
    assign probe_wrap = (probe_sum >= {1'b0, eff_size}) ?
                        SIZE_W'(probe_sum - {1'b0, eff_size}) : probe_sum[SIZE_W-1:0];

    assign flags.start     = start;
    assign flags.is_clear  = (item_reg.command == CMD_CLEAR);
    assign flags.skip      = (item_reg.ch == '0) || ovf_reg;
    assign flags.mod_busy  = mod_busy;
    assign flags.hit       = (rd_char == item_reg.ch) && (rd_parent == cur_reg);
    assign flags.empty     = (rd_char == '0);
    assign flags.next_home = (probe_wrap == home_reg);
    assign flags.clr_more  = (clr_reg != IDX_W'(TABLE_DEPTH - 1));

    assign mod_start    = (ctrl.act == ACT_MUL) || (ctrl.act == ACT_SAVE_STEP);
    assign mod_dividend = (ctrl.act == ACT_MUL) ? DIV_W'(item_reg.ch) :
                          DIV_W'(cur_reg) + DIV_W'(prod_reg);

    assign ram_rd_en   = (ctrl.act == ACT_READ);
    assign ram_wr_en   = (ctrl.act == ACT_INSERT) || (ctrl.act == ACT_CLR_WRITE);
    assign ram_wr_addr = (ctrl.act == ACT_INSERT) ? IDX_W'(probe_reg) : clr_reg;
    always_comb
    begin
        if (ctrl.act == ACT_INSERT)
        begin
            ram_wr_data = {item_reg.ch, cur_reg};
        end
        else if (clr_reg == '0)
        begin
            ram_wr_data = {ROOT_CHAR, IDX_W'(0)};
        end
        else
        begin
            ram_wr_data = '0;
        end
    end

    always_comb
    begin
        item_next  = item_reg;
        cur_next   = cur_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        ins_next   = ins_reg;
        prod_next  = prod_reg;
        step_next  = step_reg;
        home_next  = home_reg;
        probe_next = probe_reg;
        clr_next   = clr_reg;
        case (ctrl.act)
            ACT_LATCH:
            begin
                item_next = item;
            end
            ACT_BEGIN:
            begin
                ins_next = 1'b0;
                if (item_reg.command == CMD_INTERN && item_reg.first)
                begin
                    cur_next = '0;
                    len_next = '0;
                    ovf_next = 1'b0;
                end
            end
            ACT_MUL:
            begin
                prod_next = {{CHAR_W{1'b0}}, item_reg.ch} * {{CHAR_W{1'b0}}, item_reg.ch};
            end
            ACT_SAVE_STEP:
            begin
                step_next = mod_rem;
            end
            ACT_SAVE_HOME:
            begin
                home_next  = mod_rem;
                probe_next = mod_rem;
            end
            ACT_ADVANCE:
            begin
                probe_next = probe_wrap;
            end
            ACT_INSERT:
            begin
                ins_next = 1'b1;
            end
            ACT_ACCEPT_NODE:
            begin
                cur_next = IDX_W'(probe_reg);
                if (len_reg != LEN_MAX)
                begin
                    len_next = len_reg + 1'b1;
                end
            end
            ACT_SET_OVF:
            begin
                ovf_next = 1'b1;
            end
            ACT_CLR_INIT:
            begin
                cur_next = '0;
                len_next = '0;
                ovf_next = 1'b0;
                ins_next = 1'b0;
                clr_next = '0;
            end
            ACT_CLR_WRITE:
            begin
                clr_next = clr_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            ins_reg  <= 1'b0;
            size_reg <= SIZE_RESET;
        end
        else
        begin
            cur_reg <= cur_next;
            len_reg <= len_next;
            ovf_reg <= ovf_next;
            ins_reg <= ins_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        prod_reg  <= prod_next;
        step_reg  <= step_next;
        home_reg  <= home_next;
        probe_reg <= probe_next;
        clr_reg   <= clr_next;
    end

    assign cfg_ready            = !busy;
    assign result_valid         = (ctrl.act == ACT_EMIT);
    assign result.node          = NODE_W'(cur_reg);
    assign result.prefix_length = len_reg;
    assign result.inserted      = ins_reg;
    assign result.overflow      = ovf_reg;

    `HTSI_ASSERT(a_insert_only_empty, ctrl.act == ACT_INSERT |-> flags.empty, "insert into occupied entry")
    `HTSI_ASSERT(a_mod_done_on_save, ctrl.act == ACT_SAVE_STEP || ctrl.act == ACT_SAVE_HOME |-> !flags.mod_busy, "remainder taken early")
    `HTSI_ASSERT(a_ins_excludes_ovf, result_valid && result.inserted |-> !result.overflow, "insert reported with overflow")
    `HTSI_ASSERT(a_probe_in_range, ctrl.act == ACT_READ |-> probe_reg < eff_size, "probe outside table")

endmodule

// ===== sim/hashed_trie_symbol_interner_tb.sv =====
// Self-checking testbench for hashed_trie_symbol_interner: a directed table, then random names.
// Results are checked field by field against a behavioral hashed trie in the bench, or the
// table for typed rows. Depends on htsi_pkg and the hashed_trie_symbol_interner RTL.
module hashed_trie_symbol_interner_tb
    import htsi_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1500;
    localparam int POOL         = 12;
    localparam int MAX_NAME     = 10;
    localparam int LONG_NAME    = 520;

    localparam int unsigned SIZE_CHOICES [16] = '{0, 2, 3, 5, 7, 11, 13, 31, 127, 509, 1021,
                                                  2081, 4093, 4096, 4097, 8191};

    localparam result_t RESULT_ROOT      = '{node: '0, prefix_length: '0, inserted: 1'b0,
                                             overflow: 1'b0};
    localparam result_t RESULT_ROOT_FULL = '{node: '0, prefix_length: '0, inserted: 1'b0,
                                             overflow: 1'b1};

    typedef enum bit {ROW_ITEM, ROW_SIZE} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [SIZE_W-1:0] size_value;
        logic              command;
        logic [CHAR_W-1:0] ch;
        logic              first;
        bit                typed;
        result_t           want;
    } row_t;

    row_t directed_plan [29] = '{
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h00, 1'b1, 1'b1, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_CLEAR,  8'hFF, 1'b1, 1'b1, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h41, 1'b1, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h42, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'hFF, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h41, 1'b1, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h42, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h00, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h01, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_SIZE, 13'd3,    CMD_INTERN, 8'h00, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h43, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h03, 1'b1, 1'b1, RESULT_ROOT_FULL},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h44, 1'b0, 1'b1, RESULT_ROOT_FULL},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h00, 1'b0, 1'b1, RESULT_ROOT_FULL},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h01, 1'b1, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h02, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h04, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h05, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_SIZE, 13'd0,    CMD_INTERN, 8'h00, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h07, 1'b1, 1'b0, RESULT_ROOT},
        '{ROW_SIZE, 13'd8191, CMD_INTERN, 8'h00, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_CLEAR,  8'h00, 1'b0, 1'b1, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h80, 1'b1, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h80, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_SIZE, 13'd4096, CMD_INTERN, 8'h00, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'hFF, 1'b1, 1'b0, RESULT_ROOT},
        '{ROW_SIZE, 13'd2,    CMD_INTERN, 8'h00, 1'b0, 1'b0, RESULT_ROOT},
        '{ROW_ITEM, 13'd0,    CMD_INTERN, 8'h02, 1'b1, 1'b0, RESULT_ROOT},
        '{ROW_SIZE, 13'd2081, CMD_INTERN, 8'h00, 1'b0, 1'b0, RESULT_ROOT}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    item_t             item = '0;
    logic              result_valid;
    result_t           result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data = '0;

    logic [CHAR_W-1:0] trie_char [DEPTH];
    logic [NODE_W-1:0] trie_parent [DEPTH];
    logic [NODE_W-1:0] cur_node;
    logic [LEN_W-1:0]  cur_len;
    logic              name_full;
    logic [SIZE_W-1:0] size_reg;

    result_t           pending_results [$];
    int                fail_count = 0;
    int                items_sent = 0;
    bit                steady = 1'b0;

    logic [CHAR_W-1:0] pool_chars [POOL][MAX_NAME];
    int                pool_len [POOL];

    hashed_trie_symbol_interner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void clear_trie();
        for (int i = 0; i < DEPTH; i++)
        begin
            trie_char[i]   = '0;
            trie_parent[i] = '0;
        end
        trie_char[0] = ROOT_CHAR;
        cur_node     = '0;
        cur_len      = '0;
        name_full    = 1'b0;
    endfunction

    function automatic result_t next_trie_result(input item_t it);
        int unsigned sz;
        int unsigned stride;
        int unsigned home;
        int unsigned probe;
        bit          claimed;
        bit          done;
        claimed = 1'b0;
        if (it.command == CMD_CLEAR)
        begin
            clear_trie();
            return RESULT_ROOT;
        end
        if (it.first)
        begin
            cur_node  = '0;
            cur_len   = '0;
            name_full = 1'b0;
        end
        if (it.ch != 0 && !name_full)
        begin
            sz = size_reg;
            if (sz < 3)
                sz = 3;
            if (sz > DEPTH)
                sz = DEPTH;
            stride = it.ch % sz;
            home   = (cur_node + it.ch * it.ch) % sz;
            probe  = home;
            done   = 1'b0;
            while (!done)
            begin
                if (trie_char[probe] == it.ch && trie_parent[probe] == cur_node)
                    done = 1'b1;
                else if (trie_char[probe] == 0)
                begin
                    trie_char[probe]   = it.ch;
                    trie_parent[probe] = cur_node;
                    claimed = 1'b1;
                    done    = 1'b1;
                end
                else
                begin
                    probe += stride;
                    if (probe >= sz)
                        probe -= sz;
                    if (probe == home)
                    begin
                        name_full = 1'b1;
                        done      = 1'b1;
                    end
                end
            end
            if (!name_full)
            begin
                cur_node = NODE_W'(probe);
                if (cur_len < LEN_MAX)
                    cur_len++;
            end
        end
        return '{node: cur_node, prefix_length: cur_len, inserted: claimed,
                 overflow: name_full};
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        if ($urandom_range(4) == 0)
            return SIZE_W'($urandom_range(0, 8191));
        return SIZE_W'(SIZE_CHOICES[$urandom_range(0, 15)]);
    endfunction

    task automatic send(input item_t it, input bit typed, input result_t want);
        result_t predicted;
        bit      taken;
        taken = 1'b0;
        if (!steady && $urandom_range(19) == 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 60)) @(negedge clk);
        end
        while (!taken)
        begin
            @(negedge clk);
            if (!steady && $urandom_range(99) < 37)
                start <= 1'b0;
            else
            begin
                start <= 1'b1;
                item  <= it;
            end
            @(posedge clk);
            taken = start && !busy;
        end
        predicted = next_trie_result(it);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic send_name(input int k, input int from, input int upto, input bit mark_first);
        for (int j = from; j < upto; j++)
            send('{command: CMD_INTERN, ch: pool_chars[k][j], first: mark_first && j == from},
                 1'b0, RESULT_ROOT);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        size_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result node %0d length %0d inserted %0b overflow %0b",
                         $time, result.node, result.prefix_length, result.inserted,
                         result.overflow);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.node !== want.node)
                begin
                    $display("%0t: node expected %0d got %0d", $time, want.node, result.node);
                    fail_count++;
                end
                if (result.prefix_length !== want.prefix_length)
                begin
                    $display("%0t: prefix_length expected %0d got %0d", $time,
                             want.prefix_length, result.prefix_length);
                    fail_count++;
                end
                if (result.inserted !== want.inserted)
                begin
                    $display("%0t: inserted expected %0b got %0b", $time, want.inserted,
                             result.inserted);
                    fail_count++;
                end
                if (result.overflow !== want.overflow)
                begin
                    $display("%0t: overflow expected %0b got %0b", $time, want.overflow,
                             result.overflow);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #80_000_000;
        $display("[hashed_trie_symbol_interner] ERROR");
        $finish;
    end

    initial
    begin
        row_t row;
        int   base;
        int   phase_end;
        int   roll;
        int   k;
        int   from;
        int   shared;
        bit   narrow;
        bit   long_done;

        clear_trie();
        size_reg = SIZE_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.kind == ROW_SIZE)
                write_size(row.size_value);
            else
                send('{command: row.command, ch: row.ch, first: row.first}, row.typed,
                     row.want);
        end

        base      = items_sent;
        long_done = 1'b0;
        while (items_sent < base + RANDOM_ITEMS)
        begin
            write_size(pick_size());
            if ($urandom_range(2) == 0)
                send('{command: CMD_CLEAR, ch: CHAR_W'($urandom_range(0, 255)),
                       first: 1'($urandom_range(1))}, 1'b0, RESULT_ROOT);

            for (int n = 0; n < POOL; n++)
            begin
                pool_len[n] = $urandom_range(1, MAX_NAME);
                narrow = 1'($urandom_range(1));
                for (int j = 0; j < MAX_NAME; j++)
                    pool_chars[n][j] = narrow ? CHAR_W'(8'h61 + $urandom_range(3))
                                              : CHAR_W'($urandom_range(1, 255));
                if (n > 0 && $urandom_range(1) == 1)
                begin
                    shared = $urandom_range(0, pool_len[n-1]);
                    for (int j = 0; j < shared; j++)
                        pool_chars[n][j] = pool_chars[n-1][j];
                end
            end

            phase_end = items_sent + $urandom_range(30, 90);
            while (items_sent < phase_end && items_sent < base + RANDOM_ITEMS)
            begin
                steady = items_sent - base >= 300 && items_sent - base < 650;
                roll   = $urandom_range(99);
                k      = $urandom_range(0, POOL - 1);
                if (roll < 78)
                    send_name(k, 0, pool_len[k], 1'b1);
                else if (roll < 88)
                begin
                    from = $urandom_range(0, pool_len[k] - 1);
                    send_name(k, from, $urandom_range(from + 1, pool_len[k]),
                              1'($urandom_range(1)));
                end
                else if (roll < 98)
                    send('{command: $urandom_range(39) == 0 ? CMD_CLEAR : CMD_INTERN,
                           ch: CHAR_W'($urandom_range(0, 255)), first: 1'($urandom_range(1))},
                         1'b0, RESULT_ROOT);
                else
                    drain_results();
            end
            steady = 1'b0;

            if (!long_done && items_sent - base >= 700)
            begin
                long_done = 1'b1;
                write_size(13'd4093);
                send('{command: CMD_CLEAR, ch: '0, first: 1'b0}, 1'b0, RESULT_ROOT);
                for (int j = 0; j < LONG_NAME; j++)
                    send('{command: CMD_INTERN, ch: CHAR_W'($urandom_range(1, 255)),
                           first: j == 0}, 1'b0, RESULT_ROOT);
            end
        end

        drain_results();
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("[hashed_trie_symbol_interner] OK");
        else
            $display("[hashed_trie_symbol_interner] ERROR");
        $finish;
    end

endmodule
